[rtl/core/complex_arith_unit_assert.svh]
// ----------------------------------------------------------------------------
// Complex arithmetic unit assertion macros
// Concurrent assertion wrappers; they vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITH_UNIT_ASSERT_SVH
`define COMPLEX_ARITH_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define CAU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("complex_arith_unit: assertion failed");
// Next-cycle implication, checked out of reset.
`define CAU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("complex_arith_unit: assertion failed");
`else
`define CAU_ASSERT_IMP(lbl, ante, cons)
`define CAU_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[rtl/core/cau_pkg.sv]
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Payload types, operation codes and fixed-point widths shared by the unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  // Fixed-point format: signed Q7.8.
  localparam int DataWidth = 16;
  localparam int FracBits  = 8;
  // One quotient bit per divider stage.
  localparam int DivSteps  = DataWidth;
  // Product width, magnitude width and divider remainder width.
  localparam int ProdWidth = 2 * DataWidth;
  localparam int MagWidth  = ProdWidth + 1;
  localparam int RemWidth  = 3 * DataWidth;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_DIV = 2'd3
  } cau_mode_t;

  typedef struct packed {
    cau_mode_t                    mode;
    logic signed [DataWidth-1:0]  a_re;
    logic signed [DataWidth-1:0]  a_im;
    logic signed [DataWidth-1:0]  b_re;
    logic signed [DataWidth-1:0]  b_im;
  } cau_in_t;

  typedef struct packed {
    logic signed [DataWidth-1:0]  res_re;
    logic signed [DataWidth-1:0]  res_im;
    logic                         overflow;
    logic                         div_by_zero;
  } cau_out_t;

  // One result part in sign-magnitude form while it moves down the pipe.
  typedef struct packed {
    logic                 neg;
    logic                 big;
    logic [MagWidth-1:0]  mag;
    logic [RemWidth-1:0]  rem;
  } cau_lane_t;

  // Pipeline word between the front end and the divider stages.
  typedef struct packed {
    logic                  valid;
    logic                  is_div;
    logic                  dz;
    cau_lane_t             re;
    cau_lane_t             im;
    logic [ProdWidth-1:0]  den;
  } cau_mid_t;

endpackage

[rtl/core/complex_arith_unit.sv]
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Pipelined add, subtract, multiply and divide of Q7.8 complex operands
// with saturation, overflow and divide-by-zero flags.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                       Handshake
//  -------  --------------------------  ---------------------------------
//  input    start, busy, in_data        taken when start is high, busy low
//  result   out_valid, out_data         one-cycle strobe, cannot be held
//
// One item enters per clock cycle; busy stays low. Each item passes
// through two front stages, the divider setup, the 16-stage restoring
// divider (one quotient bit per stage) and the output register. All modes
// take the same path, so order is kept.
// Reset is synchronous and clears only the valid bits of the pipe.
//
module complex_arith_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  cau_pkg::cau_in_t   in_data,
  output logic               out_valid,
  output cau_pkg::cau_out_t  out_data
);

`include "complex_arith_unit_assert.svh"

  localparam int DW      = cau_pkg::DataWidth;
  localparam int MW      = cau_pkg::MagWidth;
  localparam int Latency = cau_pkg::DivSteps + 4;

  localparam logic [MW-1:0] MagLim = MW'(1) << (DW - 1);
  localparam logic [DW-1:0] CodeMax = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] CodeMin = {1'b1, {(DW-1){1'b0}}};

  cau_pkg::cau_mid_t mid, fin;
  logic              in_take;

  assign busy    = 1'b0;
  assign in_take = start && !busy;

  cau_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_take (in_take),
    .in_data (in_data),
    .mid_out (mid)
  );

  cau_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .mid_in  (mid),
    .div_out (fin)
  );

  // Saturation of one sign-magnitude part; bit DW is the overflow flag.
  function automatic logic [DW:0] sat_part(input cau_pkg::cau_lane_t p);
    logic [DW:0] r;
    if (p.neg) begin
      if (p.big || (p.mag > MagLim)) begin
        r = {1'b1, CodeMin};
      end else begin
        r = {1'b0, DW'(-p.mag)};
      end
    end else begin
      if (p.big || (p.mag > (MagLim - MW'(1)))) begin
        r = {1'b1, CodeMax};
      end else begin
        r = {1'b0, p.mag[DW-1:0]};
      end
    end
    return r;
  endfunction

  logic [DW:0]       sat_re, sat_im;
  cau_pkg::cau_out_t out_nxt, out_data_r;
  logic              out_valid_r;

  // Final saturation into the output register.
  always_comb begin
    sat_re              = sat_part(fin.re);
    sat_im              = sat_part(fin.im);
    out_nxt.res_re      = sat_re[DW-1:0];
    out_nxt.res_im      = sat_im[DW-1:0];
    out_nxt.overflow    = sat_re[DW] | sat_im[DW];
    out_nxt.div_by_zero = fin.dz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A result is always the one taken a fixed latency earlier.
  `CAU_ASSERT_IMP(a_latency, out_valid, $past(in_take, Latency))
  // A zero divisor gives a clean zero result.
  `CAU_ASSERT_IMP(a_dz_zero, out_valid && out_data.div_by_zero, (out_data.res_re == '0) && (out_data.res_im == '0) && !out_data.overflow)
  // Overflow leaves at least one part at a limit code.
  `CAU_ASSERT_IMP(a_ovf_sat, out_valid && out_data.overflow, (out_data.res_re == CodeMax) || (out_data.res_re == CodeMin) || (out_data.res_im == CodeMax) || (out_data.res_im == CodeMin))

endmodule

[rtl/core/cau_front.sv]
// ----------------------------------------------------------------------------
// Complex arithmetic unit front end
// Stage one forms the partial products and sums, stage two combines them
// into sign-magnitude result parts and the squared divisor magnitude.
// ----------------------------------------------------------------------------
module cau_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_take,
  input  cau_pkg::cau_in_t  in_data,
  output cau_pkg::cau_mid_t mid_out
);

  localparam int DW = cau_pkg::DataWidth;
  localparam int PW = cau_pkg::ProdWidth;
  localparam int MW = cau_pkg::MagWidth;
  localparam int RW = cau_pkg::RemWidth;

  // Stage one registers.
  logic                    s1_valid_r;
  cau_pkg::cau_mode_t      s1_mode_r;
  logic signed [PW-1:0]    p_rr_r, p_ii_r, p_ri_r, p_ir_r, p_bb_re_r, p_bb_im_r;
  logic signed [DW:0]      s_re_r, s_im_r;
  logic signed [DW:0]      s_re_nxt, s_im_nxt;

  // Sum or difference, one bit wider than the operands.
  always_comb begin
    if (in_data.mode == cau_pkg::MODE_SUB) begin
      s_re_nxt = {in_data.a_re[DW-1], in_data.a_re} - {in_data.b_re[DW-1], in_data.b_re};
      s_im_nxt = {in_data.a_im[DW-1], in_data.a_im} - {in_data.b_im[DW-1], in_data.b_im};
    end else begin
      s_re_nxt = {in_data.a_re[DW-1], in_data.a_re} + {in_data.b_re[DW-1], in_data.b_re};
      s_im_nxt = {in_data.a_im[DW-1], in_data.a_im} + {in_data.b_im[DW-1], in_data.b_im};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_take;
    end
  end

  // Full-width products, one multiplier per register.
  always_ff @(posedge clk) begin
    s1_mode_r <= in_data.mode;
    p_rr_r    <= PW'(in_data.a_re) * PW'(in_data.b_re);
    p_ii_r    <= PW'(in_data.a_im) * PW'(in_data.b_im);
    p_ri_r    <= PW'(in_data.a_re) * PW'(in_data.b_im);
    p_ir_r    <= PW'(in_data.a_im) * PW'(in_data.b_re);
    p_bb_re_r <= PW'(in_data.b_re) * PW'(in_data.b_re);
    p_bb_im_r <= PW'(in_data.b_im) * PW'(in_data.b_im);
    s_re_r    <= s_re_nxt;
    s_im_r    <= s_im_nxt;
  end

  // Stage two: combine products and take sign and magnitude.
  logic signed [MW-1:0] v_re, v_im;
  logic [MW-1:0]        abs_re, abs_im;
  logic [PW-1:0]        den;
  cau_pkg::cau_mid_t    mid_nxt, mid_r;

  always_comb begin
    case (s1_mode_r)
      cau_pkg::MODE_MUL: begin
        v_re = MW'(p_rr_r) - MW'(p_ii_r);
        v_im = MW'(p_ri_r) + MW'(p_ir_r);
      end
      cau_pkg::MODE_DIV: begin
        v_re = MW'(p_rr_r) + MW'(p_ii_r);
        v_im = MW'(p_ir_r) - MW'(p_ri_r);
      end
      default: begin
        v_re = MW'(s_re_r);
        v_im = MW'(s_im_r);
      end
    endcase
    abs_re = v_re[MW-1] ? MW'(-v_re) : MW'(v_re);
    abs_im = v_im[MW-1] ? MW'(-v_im) : MW'(v_im);
    den    = $unsigned(p_bb_re_r) + $unsigned(p_bb_im_r);

    mid_nxt        = '0;
    mid_nxt.valid  = s1_valid_r;
    mid_nxt.is_div = (s1_mode_r == cau_pkg::MODE_DIV);
    mid_nxt.dz     = (s1_mode_r == cau_pkg::MODE_DIV) && (den == '0);
    mid_nxt.den    = den;
    mid_nxt.re.neg = v_re[MW-1];
    mid_nxt.im.neg = v_im[MW-1];
    mid_nxt.re.rem = RW'(0);
    mid_nxt.im.rem = RW'(0);
    // Multiply rescales the magnitude, which truncates toward zero.
    if (s1_mode_r == cau_pkg::MODE_MUL) begin
      mid_nxt.re.mag = abs_re >> cau_pkg::FracBits;
      mid_nxt.im.mag = abs_im >> cau_pkg::FracBits;
    end else begin
      mid_nxt.re.mag = abs_re;
      mid_nxt.im.mag = abs_im;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r.valid <= 1'b0;
    end else begin
      mid_r <= mid_nxt;
    end
  end

  assign mid_out = mid_r;

endmodule

[rtl/core/cau_div.sv]
// ----------------------------------------------------------------------------
// Complex arithmetic unit divider pipeline
// A setup stage scales the numerators and flags quotients out of range,
// then one restoring step per stage yields one quotient bit per part.
// Items of other modes ride through unchanged.
// ----------------------------------------------------------------------------
module cau_div (
  input  logic              clk,
  input  logic              rst_n,
  input  cau_pkg::cau_mid_t mid_in,
  output cau_pkg::cau_mid_t div_out
);

  localparam int DW = cau_pkg::DataWidth;
  localparam int MW = cau_pkg::MagWidth;
  localparam int RW = cau_pkg::RemWidth;
  localparam int NS = cau_pkg::DivSteps;

  cau_pkg::cau_mid_t stg_r [NS+1];
  cau_pkg::cau_mid_t prep_nxt;
  logic [RW-1:0]     num_re, num_im, den_top;
  logic              div_go;

  // Setup: remainder starts at num << FracBits; quotients at or above
  // 2^DataWidth only need to be known as too large.
  always_comb begin
    num_re   = RW'(mid_in.re.mag) << cau_pkg::FracBits;
    num_im   = RW'(mid_in.im.mag) << cau_pkg::FracBits;
    den_top  = RW'(mid_in.den) << DW;
    div_go   = mid_in.is_div && !mid_in.dz;
    prep_nxt = mid_in;
    if (mid_in.is_div) begin
      prep_nxt.re.rem = num_re;
      prep_nxt.im.rem = num_im;
      prep_nxt.re.mag = MW'(0);
      prep_nxt.im.mag = MW'(0);
      prep_nxt.re.big = div_go && (num_re >= den_top);
      prep_nxt.im.big = div_go && (num_im >= den_top);
    end else begin
      prep_nxt.re.big = 1'b0;
      prep_nxt.im.big = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r[0].valid <= 1'b0;
    end else begin
      stg_r[0] <= prep_nxt;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar k = 0; k < NS; k++) begin : g_step
    localparam int Bit = NS - 1 - k;
    cau_pkg::cau_mid_t step_nxt;
    logic [RW-1:0]     dsh;

    always_comb begin
      dsh      = RW'(stg_r[k].den) << Bit;
      step_nxt = stg_r[k];
      if (stg_r[k].is_div && !stg_r[k].dz) begin
        if (!stg_r[k].re.big && (stg_r[k].re.rem >= dsh)) begin
          step_nxt.re.rem      = stg_r[k].re.rem - dsh;
          step_nxt.re.mag[Bit] = 1'b1;
        end
        if (!stg_r[k].im.big && (stg_r[k].im.rem >= dsh)) begin
          step_nxt.im.rem      = stg_r[k].im.rem - dsh;
          step_nxt.im.mag[Bit] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stg_r[k+1].valid <= 1'b0;
      end else begin
        stg_r[k+1] <= step_nxt;
      end
    end
  end

  assign div_out = stg_r[NS];

endmodule
